FILE: hw/rtl/rdmd_pkg.sv
// Package for the RED drop and mark decision block.
// Holds the payload structs and the action, cause and register codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rdmd_pkg;

    typedef struct packed {
        logic [3:0]  queue_index;
        logic [23:0] avg_length;
        logic [15:0] current_length;
        logic [15:0] min_threshold;
        logic [15:0] max_threshold;
        logic [15:0] random_fraction;
    } in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] cause;
    } out_t;

    localparam logic [1:0] ACT_ACCEPT = 2'd0;
    localparam logic [1:0] ACT_DROP   = 2'd1;
    localparam logic [1:0] ACT_MARK   = 2'd2;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_PROB = 2'd1;
    localparam logic [1:0] CAUSE_AVG  = 2'd2;
    localparam logic [1:0] CAUSE_CUR  = 2'd3;

    localparam logic [3:0] CFG_MAXP = 4'd0;
    localparam logic [3:0] CFG_MARK = 4'd1;

    localparam logic [15:0] MAXP_RESET = 16'd6554;

endpackage
`default_nettype wire

FILE: hw/rtl/rdmd_div.sv
// Radix-2 restoring divider for the base drop probability, one quotient bit a cycle.
// Produces a 32-bit quotient of a 56-bit dividend by a 24-bit divisor.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rdmd_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [39:0] product,
    input  wire logic [23:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [23:0] rem_reg, rem_next;
    logic [31:0] bits_reg, bits_next;
    logic [31:0] quot_reg, quot_next;
    logic [23:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, bits_reg[31]};
        if (start) begin
            rem_next  = product[39:16];
            bits_next = {product[15:0], 16'h0000};
            den_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bits_next = {bits_reg[30:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = 24'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[30:0], 1'b1};
            end else begin
                rem_next  = trial[23:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/red_drop_mark_decision_top.sv
// Top level of the RED drop and mark decision block.
// Depends on rdmd_pkg and rdmd_div.
//
// One decision is made per packet transaction, one at a time. A packet for a queue in range
// whose average lies between its thresholds takes the probability path: the 32-step serial
// divider that forms the base probability, followed by a multiply, a subtraction and a
// second multiply for the final comparison. Any other packet skips that path and has its
// result set in the read state or, for a queue out of range, straight from idle. A result
// that is not taken holds the next decision back until it is. The per-queue counters sit
// in a small synchronous memory with valid bits cleared by reset, so no clearing pass is
// needed.
`timescale 1ns / 1ps
`default_nettype none
module red_drop_mark_decision_top #(
    parameter int NUM_QUEUES = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wen,
    input  wire logic [3:0]     cfg_index,
    input  wire logic [15:0]    cfg_wdata,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rdmd_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rdmd_pkg::out_t      m_data
);
    localparam int AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CPB  = 3'd3;
    localparam logic [2:0] ST_MULH = 3'd4;
    localparam logic [2:0] ST_MULL = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [1:0] RG_PROB = 2'd0;
    localparam logic [1:0] RG_AVG  = 2'd1;
    localparam logic [1:0] RG_CUR  = 2'd2;
    localparam logic [1:0] RG_NONE = 2'd3;

    logic [16:0] mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] vld_reg;
    logic [16:0] rd_reg;

    logic [2:0]  state_reg, state_next;
    logic [15:0] maxp_reg;
    logic        mark_reg;
    logic [15:0] rnd_reg;
    logic [1:0]  region_reg;
    logic [AW-1:0] addr_reg;
    logic [15:0] cnt_reg, cnt_next;
    logic [39:0] prod_reg;
    logic [23:0] den_reg;
    logic [31:0] pb_reg;
    logic [47:0] cpb_reg;
    logic [48:0] ph_reg;
    logic [47:0] pl_reg;
    logic [31:0] x_reg;
    logic [32:0] d_reg;
    rdmd_pkg::out_t res_reg, res_next;
    logic        m_valid_reg;
    rdmd_pkg::out_t m_data_reg;

    logic        accept;
    logic [AW+3:0] q_ext;
    logic [AW-1:0] q_addr;
    logic        q_in_range;
    logic [23:0] lo8, hi8;
    logic [1:0]  region;
    logic [16:0] cur_cnt;
    logic        div_start, div_done;
    logic [31:0] div_quot;
    logic        wr_en;
    logic [16:0] wr_data;
    logic [1:0]  hit_act;
    logic [65:0] lhs;
    logic        hit;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign q_ext      = {{AW{1'b0}}, s_data.queue_index};
    assign q_addr     = q_ext[AW-1:0];
    assign q_in_range = ({5'd0, s_data.queue_index} < 9'(NUM_QUEUES));
    assign lo8        = {s_data.min_threshold, 8'h00};
    assign hi8        = {s_data.max_threshold, 8'h00};
    assign cur_cnt    = vld_reg[addr_reg] ? rd_reg : 17'd0;
    assign hit_act    = mark_reg ? rdmd_pkg::ACT_MARK : rdmd_pkg::ACT_DROP;
    assign lhs        = {1'b0, ph_reg, 16'h0000} + {18'd0, pl_reg};
    assign hit        = lhs <= {2'b00, pb_reg, 32'h0};

    always_comb begin
        if (lo8 <= s_data.avg_length && s_data.avg_length < hi8) begin
            region = RG_PROB;
        end else if (s_data.avg_length >= hi8) begin
            region = RG_AVG;
        end else if (s_data.current_length >= s_data.max_threshold) begin
            region = RG_CUR;
        end else begin
            region = RG_NONE;
        end
    end

    always_comb begin
        if (cur_cnt[16]) begin
            cnt_next = 16'd0;
        end else if (cur_cnt[15:0] == 16'hFFFF) begin
            cnt_next = 16'hFFFF;
        end else begin
            cnt_next = cur_cnt[15:0] + 16'd1;
        end
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_data    = 17'd0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (q_in_range) begin
                        state_next = ST_READ;
                    end else begin
                        res_next   = '{action: rdmd_pkg::ACT_ACCEPT,
                                       cause: rdmd_pkg::CAUSE_NONE};
                        state_next = ST_FIN;
                    end
                end
            end
            ST_READ: begin
                case (region_reg)
                    RG_PROB: begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    RG_AVG: begin
                        wr_en      = 1'b1;
                        res_next   = '{action: hit_act, cause: rdmd_pkg::CAUSE_AVG};
                        state_next = ST_FIN;
                    end
                    RG_CUR: begin
                        wr_en      = 1'b1;
                        res_next   = '{action: hit_act, cause: rdmd_pkg::CAUSE_CUR};
                        state_next = ST_FIN;
                    end
                    default: begin
                        wr_en      = 1'b1;
                        wr_data    = 17'h1FFFF;
                        res_next   = '{action: rdmd_pkg::ACT_ACCEPT,
                                       cause: rdmd_pkg::CAUSE_NONE};
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_CPB;
                end
            end
            ST_CPB: begin
                state_next = ST_MULH;
            end
            ST_MULH: begin
                state_next = ST_MULL;
            end
            ST_MULL: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                wr_en = 1'b1;
                if (cpb_reg[47:32] != 16'd0 || hit) begin
                    wr_data  = 17'd0;
                    res_next = '{action: hit_act, cause: rdmd_pkg::CAUSE_PROB};
                end else begin
                    wr_data  = {1'b0, cnt_reg};
                    res_next = '{action: rdmd_pkg::ACT_ACCEPT,
                                 cause: rdmd_pkg::CAUSE_NONE};
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rdmd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .product  (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= mem[q_addr];
        end
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rnd_reg    <= s_data.random_fraction;
            region_reg <= region;
            addr_reg   <= q_addr;
            den_reg    <= 24'(hi8 - lo8);
            prod_reg   <= 40'(maxp_reg) * 40'(24'(s_data.avg_length - lo8));
        end
        if (state_reg == ST_READ) begin
            cnt_reg  <= cnt_next;
        end
        if (div_done) begin
            pb_reg <= div_quot;
        end
        if (state_reg == ST_CPB) begin
            cpb_reg <= 48'(cnt_reg) * 48'(pb_reg);
            x_reg   <= {rnd_reg, 16'h0000} + 32'd1;
        end
        if (state_reg == ST_MULH) begin
            d_reg  <= 33'h1_0000_0000 - {1'b0, cpb_reg[31:0]};
        end
        if (state_reg == ST_MULL) begin
            ph_reg <= 49'(x_reg) * 49'(d_reg[32:16]);
            pl_reg <= 48'(x_reg) * 48'(d_reg[15:0]);
        end
        res_reg <= res_next;
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            maxp_reg    <= rdmd_pkg::MAXP_RESET;
            mark_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (cfg_wen && cfg_index == rdmd_pkg::CFG_MAXP) begin
                maxp_reg <= cfg_wdata;
            end
            if (cfg_wen && cfg_index == rdmd_pkg::CFG_MARK) begin
                mark_reg <= cfg_wdata[0];
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire
